// ===== rtl/core/glbcp_pkg.sv =====
// Shared constants, status codes and result type of the GLB container parser.
package glbcp_pkg;

    localparam logic [31:0] GLB_MAGIC       = 32'h4654_6C67;
    localparam logic [31:0] GLB_VERSION     = 32'd2;
    localparam logic [31:0] CHUNK_TYPE_JSON = 32'h4E4F_534A;
    localparam logic [31:0] CHUNK_TYPE_BIN  = 32'h004E_4942;
    localparam logic [31:0] FILE_HDR_BYTES  = 32'd12;
    localparam logic [31:0] CHUNK_HDR_BYTES = 32'd8;

    localparam logic [2:0] ST_OK          = 3'd0;
    localparam logic [2:0] ST_TOO_SMALL   = 3'd1;
    localparam logic [2:0] ST_BAD_MAGIC   = 3'd2;
    localparam logic [2:0] ST_BAD_VERSION = 3'd3;
    localparam logic [2:0] ST_LEN_EXCEEDS = 3'd4;
    localparam logic [2:0] ST_OVERRUN     = 3'd5;
    localparam logic [2:0] ST_NO_JSON     = 3'd6;

    typedef struct packed {
        logic [2:0]  status;
        logic [31:0] json_offset;
        logic [31:0] json_length;
        logic [31:0] bin_offset;
        logic [31:0] bin_length;
    } result_t;

endpackage

// ===== rtl/core/glbcp_in_stage.sv =====
// Input register: holds one accepted byte word until the parser core consumes it.
module glbcp_in_stage (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] data_byte,
    input  logic       last_byte,
    input  logic       take,
    output logic       held_valid,
    output logic [7:0] held_byte,
    output logic       held_last
);

    logic       valid_reg;
    logic [7:0] byte_reg;
    logic       last_reg;

    assign in_ready   = !valid_reg || take;
    assign held_valid = valid_reg;
    assign held_byte  = byte_reg;
    assign held_last  = last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            byte_reg <= data_byte;
            last_reg <= last_byte;
        end
    end

endmodule

// ===== rtl/core/glbcp_core.sv =====
// Parser core: header checks, chunk walk and result formation, one byte per cycle while step is high.
module glbcp_core (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     step,
    input  logic [7:0]               data_byte,
    input  logic                     last_byte,
    output glbcp_pkg::result_t       result
);

    localparam logic [1:0] PH_FILE = 2'd0;
    localparam logic [1:0] PH_CHDR = 2'd1;
    localparam logic [1:0] PH_PAY  = 2'd2;
    localparam logic [1:0] PH_DONE = 2'd3;

    logic [31:0] byte_count_reg, byte_count_next;
    logic [1:0]  phase_reg, phase_next;
    logic [31:0] word_shift_reg, word_shift_next;
    logic [31:0] decl_len_reg, decl_len_next;
    logic [31:0] chunk_len_reg, chunk_len_next;
    logic [31:0] chunk_end_reg, chunk_end_next;
    logic [2:0]  hdr_idx_reg, hdr_idx_next;
    logic [2:0]  first_err_reg, first_err_next;
    logic [31:0] json_start_reg, json_start_next;
    logic [31:0] json_size_reg, json_size_next;
    logic [31:0] bin_start_reg, bin_start_next;
    logic [31:0] bin_size_reg, bin_size_next;

    logic [32:0] payload_end;
    logic [33:0] next_hdr_end;
    logic [32:0] pos_plus1;
    logic [2:0]  status;

    always_comb
    begin
        byte_count_next = (byte_count_reg == 32'hFFFF_FFFF) ? byte_count_reg
                                                            : byte_count_reg + 32'd1;
        word_shift_next = {data_byte, word_shift_reg[31:8]};
        phase_next      = phase_reg;
        decl_len_next   = decl_len_reg;
        chunk_len_next  = chunk_len_reg;
        chunk_end_next  = chunk_end_reg;
        hdr_idx_next    = hdr_idx_reg;
        first_err_next  = first_err_reg;
        json_start_next = json_start_reg;
        json_size_next  = json_size_reg;
        bin_start_next  = bin_start_reg;
        bin_size_next   = bin_size_reg;

        payload_end  = {1'b0, byte_count_reg} + 33'd1 + {1'b0, chunk_len_reg};
        next_hdr_end = {1'b0, payload_end} + {2'b00, glbcp_pkg::CHUNK_HDR_BYTES};
        pos_plus1    = {1'b0, byte_count_reg} + 33'd1;

        unique case (phase_reg)
            PH_FILE:
            begin
                if (byte_count_reg == 32'd3 && word_shift_next != glbcp_pkg::GLB_MAGIC)
                begin
                    if (first_err_reg == glbcp_pkg::ST_OK)
                        first_err_next = glbcp_pkg::ST_BAD_MAGIC;
                end
                else if (byte_count_reg == 32'd7 &&
                         word_shift_next != glbcp_pkg::GLB_VERSION)
                begin
                    if (first_err_reg == glbcp_pkg::ST_OK)
                        first_err_next = glbcp_pkg::ST_BAD_VERSION;
                end
                else if (byte_count_reg == glbcp_pkg::FILE_HDR_BYTES - 32'd1)
                begin
                    decl_len_next = word_shift_next;
                    if (first_err_reg == glbcp_pkg::ST_OK)
                    begin
                        chunk_end_next = glbcp_pkg::FILE_HDR_BYTES;
                        phase_next = ((glbcp_pkg::FILE_HDR_BYTES +
                                       glbcp_pkg::CHUNK_HDR_BYTES) > word_shift_next)
                                     ? PH_DONE : PH_CHDR;
                    end
                    else
                    begin
                        phase_next = PH_DONE;
                    end
                end
            end
            PH_CHDR:
            begin
                // index wraps back to zero after the eighth header byte
                hdr_idx_next = hdr_idx_reg + 3'd1;
                if (hdr_idx_reg == 3'd3)
                begin
                    chunk_len_next = word_shift_next;
                end
                else if (hdr_idx_reg == 3'd7)
                begin
                    if (payload_end > {1'b0, decl_len_reg})
                    begin
                        if (first_err_reg == glbcp_pkg::ST_OK)
                            first_err_next = glbcp_pkg::ST_OVERRUN;
                        phase_next = PH_DONE;
                    end
                    else
                    begin
                        if (word_shift_next == glbcp_pkg::CHUNK_TYPE_JSON)
                        begin
                            if (json_size_reg == 32'd0)
                            begin
                                json_start_next = pos_plus1[31:0];
                                json_size_next  = chunk_len_reg;
                            end
                        end
                        else if (word_shift_next == glbcp_pkg::CHUNK_TYPE_BIN)
                        begin
                            if (bin_size_reg == 32'd0)
                            begin
                                bin_start_next = pos_plus1[31:0];
                                bin_size_next  = chunk_len_reg;
                            end
                        end
                        chunk_end_next = payload_end[31:0];
                        if (chunk_len_reg == 32'd0)
                            phase_next = (next_hdr_end > {2'b00, decl_len_reg})
                                         ? PH_DONE : PH_CHDR;
                        else
                            phase_next = PH_PAY;
                    end
                end
            end
            PH_PAY:
            begin
                if (pos_plus1 >= {1'b0, chunk_end_reg})
                    phase_next = (({1'b0, chunk_end_reg} +
                                   {1'b0, glbcp_pkg::CHUNK_HDR_BYTES})
                                  > {1'b0, decl_len_reg}) ? PH_DONE : PH_CHDR;
            end
            PH_DONE:
            begin
            end
            default:
            begin
            end
        endcase

        // status precedence uses the state after this byte
        priority if (byte_count_next < glbcp_pkg::FILE_HDR_BYTES)
            status = glbcp_pkg::ST_TOO_SMALL;
        else if (first_err_next == glbcp_pkg::ST_BAD_MAGIC ||
                 first_err_next == glbcp_pkg::ST_BAD_VERSION)
            status = first_err_next;
        else if (decl_len_next > byte_count_next)
            status = glbcp_pkg::ST_LEN_EXCEEDS;
        else if (first_err_next == glbcp_pkg::ST_OVERRUN)
            status = glbcp_pkg::ST_OVERRUN;
        else if (json_size_next == 32'd0)
            status = glbcp_pkg::ST_NO_JSON;
        else
            status = glbcp_pkg::ST_OK;

        result.status = status;
        if (status == glbcp_pkg::ST_OK)
        begin
            result.json_offset = json_start_next;
            result.json_length = json_size_next;
            result.bin_offset  = (bin_size_next != 32'd0) ? bin_start_next : 32'd0;
            result.bin_length  = bin_size_next;
        end
        else
        begin
            result.json_offset = 32'd0;
            result.json_length = 32'd0;
            result.bin_offset  = 32'd0;
            result.bin_length  = 32'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_count_reg <= 32'd0;
            phase_reg      <= PH_FILE;
            word_shift_reg <= 32'd0;
            decl_len_reg   <= 32'd0;
            chunk_len_reg  <= 32'd0;
            chunk_end_reg  <= 32'd0;
            hdr_idx_reg    <= 3'd0;
            first_err_reg  <= glbcp_pkg::ST_OK;
            json_start_reg <= 32'd0;
            json_size_reg  <= 32'd0;
            bin_start_reg  <= 32'd0;
            bin_size_reg   <= 32'd0;
        end
        else if (step)
        begin
            if (last_byte)
            begin
                byte_count_reg <= 32'd0;
                phase_reg      <= PH_FILE;
                word_shift_reg <= 32'd0;
                decl_len_reg   <= 32'd0;
                chunk_len_reg  <= 32'd0;
                chunk_end_reg  <= 32'd0;
                hdr_idx_reg    <= 3'd0;
                first_err_reg  <= glbcp_pkg::ST_OK;
                json_start_reg <= 32'd0;
                json_size_reg  <= 32'd0;
                bin_start_reg  <= 32'd0;
                bin_size_reg   <= 32'd0;
            end
            else
            begin
                byte_count_reg <= byte_count_next;
                phase_reg      <= phase_next;
                word_shift_reg <= word_shift_next;
                decl_len_reg   <= decl_len_next;
                chunk_len_reg  <= chunk_len_next;
                chunk_end_reg  <= chunk_end_next;
                hdr_idx_reg    <= hdr_idx_next;
                first_err_reg  <= first_err_next;
                json_start_reg <= json_start_next;
                json_size_reg  <= json_size_next;
                bin_start_reg  <= bin_start_next;
                bin_size_reg   <= bin_size_next;
            end
        end
    end

endmodule

// ===== rtl/core/glbcp_out_stage.sv =====
// Output register: holds one result word until the consumer takes it.
module glbcp_out_stage (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               load,
    input  glbcp_pkg::result_t result,
    output logic               can_load,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [2:0]         status,
    output logic [31:0]        json_offset,
    output logic [31:0]        json_length,
    output logic [31:0]        bin_offset,
    output logic [31:0]        bin_length
);

    logic               valid_reg;
    glbcp_pkg::result_t data_reg;

    assign can_load    = !valid_reg || out_ready;
    assign out_valid   = valid_reg;
    assign status      = data_reg.status;
    assign json_offset = data_reg.json_offset;
    assign json_length = data_reg.json_length;
    assign bin_offset  = data_reg.bin_offset;
    assign bin_length  = data_reg.bin_length;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (can_load)
        begin
            valid_reg <= load;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load && can_load)
        begin
            data_reg <= result;
        end
    end

endmodule

// ===== rtl/core/glb_container_chunk_parser.sv =====
// Top level of the GLB container chunk parser.
// Takes one file byte per cycle unless stalled, with last_byte flagging the end of a file, and
// returns one result word per file: a status code and the offset and length of
// the first non-empty JSON and BIN chunk payloads. After the last byte of a file
// is taken from the input register, its result is registered in the output
// register. The only stall is a last byte held in the input register while the
// previous result is still waiting in the output register. The byte counter
// saturates at 2^32-1.
module glb_container_chunk_parser (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  data_byte,
    input  logic        last_byte,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [2:0]  status,
    output logic [31:0] json_offset,
    output logic [31:0] json_length,
    output logic [31:0] bin_offset,
    output logic [31:0] bin_length
);

    logic               held_valid;
    logic [7:0]         held_byte;
    logic               held_last;
    logic               can_load;
    logic               step;
    glbcp_pkg::result_t result;

    // non-last bytes never need the output register
    assign step = held_valid && (!held_last || can_load);

    glbcp_in_stage u_in (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .data_byte  (data_byte),
        .last_byte  (last_byte),
        .take       (step),
        .held_valid (held_valid),
        .held_byte  (held_byte),
        .held_last  (held_last)
    );

    glbcp_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (step),
        .data_byte (held_byte),
        .last_byte (held_last),
        .result    (result)
    );

    glbcp_out_stage u_out (
        .clk         (clk),
        .rst_n       (rst_n),
        .load        (step && held_last),
        .result      (result),
        .can_load    (can_load),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .status      (status),
        .json_offset (json_offset),
        .json_length (json_length),
        .bin_offset  (bin_offset),
        .bin_length  (bin_length)
    );

endmodule

// ===== test/glb_container_chunk_parser_test.sv =====
// Self-checking testbench for the GLB container chunk parser: byte stream in, one result per file.
module glb_container_chunk_parser_test;

    localparam int QUIET_LIMIT   = 1000;
    localparam int RANDOM_BYTES  = 400;
    localparam int CALM_BYTES    = 320;
    localparam int MIN_FILES     = 12;

    typedef enum int {
        FK_CLEAN,
        FK_MAGIC,
        FK_VERSION,
        FK_LONG_DECL,
        FK_SHORT_DECL,
        FK_OVERRUN,
        FK_TRUNCATE,
        FK_NOISE
    } file_kind_t;

    class glb_scoreboard_t;
        typedef enum logic [1:0] {
            WALK_FILE_HDR,
            WALK_CHUNK_HDR,
            WALK_PAYLOAD,
            WALK_DONE
        } walk_t;

        logic [31:0]        n_bytes;
        logic [31:0]        shift_word;
        logic [31:0]        decl_len;
        logic [31:0]        chunk_len;
        longint unsigned    next_mark;
        logic [2:0]         err;
        logic [31:0]        json_at;
        logic [31:0]        json_len;
        logic [31:0]        bin_at;
        logic [31:0]        bin_len;
        walk_t              walk;
        glbcp_pkg::result_t expected_q[$];
        int                 mismatches;
        int                 results_seen;

        function new();
            mismatches   = 0;
            results_seen = 0;
            clear();
        endfunction

        function void clear();
            n_bytes    = '0;
            shift_word = '0;
            decl_len   = '0;
            chunk_len  = '0;
            next_mark  = 0;
            err        = glbcp_pkg::ST_OK;
            json_at    = '0;
            json_len   = '0;
            bin_at     = '0;
            bin_len    = '0;
            walk       = WALK_FILE_HDR;
        endfunction

        function void flag(logic [2:0] code);
            if (err == glbcp_pkg::ST_OK)
                err = code;
        endfunction

        // next_mark points at the next chunk header here
        function void next_header();
            if (next_mark + 64'(glbcp_pkg::CHUNK_HDR_BYTES) > 64'(decl_len))
                walk = WALK_DONE;
            else
                walk = WALK_CHUNK_HDR;
        endfunction

        function void note_byte(logic [7:0] b, logic fin);
            longint unsigned    p;
            longint unsigned    idx;
            longint unsigned    start_at;
            longint unsigned    end_at;
            glbcp_pkg::result_t r;
            p = 64'(n_bytes);
            if (n_bytes != 32'hFFFF_FFFF)
                n_bytes++;
            shift_word = {b, shift_word[31:8]};
            unique case (walk)
                WALK_FILE_HDR:
                begin
                    if (p == 3 && shift_word != glbcp_pkg::GLB_MAGIC)
                        flag(glbcp_pkg::ST_BAD_MAGIC);
                    else if (p == 7 && shift_word != glbcp_pkg::GLB_VERSION)
                        flag(glbcp_pkg::ST_BAD_VERSION);
                    else if (p == 64'(glbcp_pkg::FILE_HDR_BYTES) - 1)
                    begin
                        decl_len = shift_word;
                        if (err == glbcp_pkg::ST_OK)
                        begin
                            next_mark = 64'(glbcp_pkg::FILE_HDR_BYTES);
                            next_header();
                        end
                        else
                            walk = WALK_DONE;
                    end
                end
                WALK_CHUNK_HDR:
                begin
                    idx = p - next_mark;
                    if (idx == 3)
                        chunk_len = shift_word;
                    else if (idx == 7)
                    begin
                        start_at = p + 1;
                        end_at   = start_at + 64'(chunk_len);
                        if (end_at > 64'(decl_len))
                        begin
                            flag(glbcp_pkg::ST_OVERRUN);
                            walk = WALK_DONE;
                        end
                        else
                        begin
                            if (shift_word == glbcp_pkg::CHUNK_TYPE_JSON)
                            begin
                                if (json_len == 0)
                                begin
                                    json_at  = start_at[31:0];
                                    json_len = chunk_len;
                                end
                            end
                            else if (shift_word == glbcp_pkg::CHUNK_TYPE_BIN)
                            begin
                                if (bin_len == 0)
                                begin
                                    bin_at  = start_at[31:0];
                                    bin_len = chunk_len;
                                end
                            end
                            next_mark = end_at;
                            if (chunk_len == 0)
                                next_header();
                            else
                                walk = WALK_PAYLOAD;
                        end
                    end
                end
                WALK_PAYLOAD:
                begin
                    if (p + 1 >= next_mark)
                        next_header();
                end
                default:
                begin
                end
            endcase

            if (fin)
            begin
                r = '0;
                if (n_bytes < glbcp_pkg::FILE_HDR_BYTES)
                    r.status = glbcp_pkg::ST_TOO_SMALL;
                else if (err == glbcp_pkg::ST_BAD_MAGIC || err == glbcp_pkg::ST_BAD_VERSION)
                    r.status = err;
                else if (decl_len > n_bytes)
                    r.status = glbcp_pkg::ST_LEN_EXCEEDS;
                else if (err == glbcp_pkg::ST_OVERRUN)
                    r.status = glbcp_pkg::ST_OVERRUN;
                else if (json_len == 0)
                    r.status = glbcp_pkg::ST_NO_JSON;
                else
                begin
                    r.status      = glbcp_pkg::ST_OK;
                    r.json_offset = json_at;
                    r.json_length = json_len;
                    r.bin_offset  = (bin_len != 0) ? bin_at : 32'd0;
                    r.bin_length  = bin_len;
                end
                expected_q.insert(expected_q.size(), r);
                clear();
            end
        endfunction

        function void check_result(glbcp_pkg::result_t got);
            glbcp_pkg::result_t want;
            results_seen++;
            if (expected_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result word: status %0d json %0h/%0h bin %0h/%0h",
                             got.status, got.json_offset, got.json_length,
                             got.bin_offset, got.bin_length);
                return;
            end
            want = expected_q.pop_front();
            if (got.status !== want.status || got.json_offset !== want.json_offset ||
                got.json_length !== want.json_length || got.bin_offset !== want.bin_offset ||
                got.bin_length !== want.bin_length)
            begin
                mismatches++;
                if (mismatches <= 10)
                begin
                    $display("mismatch: expected status %0d json %0h/%0h bin %0h/%0h",
                             want.status, want.json_offset, want.json_length,
                             want.bin_offset, want.bin_length);
                    $display("          actual   status %0d json %0h/%0h bin %0h/%0h",
                             got.status, got.json_offset, got.json_length,
                             got.bin_offset, got.bin_length);
                end
            end
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [7:0]  data_byte;
    logic        last_byte;
    logic        out_valid;
    logic        out_ready;
    logic [2:0]  status;
    logic [31:0] json_offset;
    logic [31:0] json_length;
    logic [31:0] bin_offset;
    logic [31:0] bin_length;

    glbcp_pkg::result_t seen_word;
    glb_scoreboard_t    sb;
    logic [7:0]         file_bytes[$];
    logic               calm;
    int                 sent_bytes;
    int                 stall_left;

    glb_container_chunk_parser dut (.*);

    assign seen_word = {status, json_offset, json_length, bin_offset, bin_length};

    always #2 clk = ~clk;

    // result side: check and random backpressure bursts
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            sb.check_result(seen_word);
        if (stall_left > 0)
        begin
            out_ready  <= 1'b0;
            stall_left = stall_left - 1;
        end
        else if (!calm && $urandom_range(0, 9) == 0)
        begin
            out_ready  <= 1'b0;
            stall_left = $urandom_range(1, 16) - 1;
        end
        else
            out_ready <= 1'b1;
    end

    initial
    begin : watchdog
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < QUIET_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("CHECKS FAILED");
        $finish;
    end

    task automatic send_byte(input logic [7:0] b, input logic fin);
        if (!calm && $urandom_range(0, 11) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge clk);
        end
        in_valid  <= 1'b1;
        data_byte <= b;
        last_byte <= fin;
        do
            @(posedge clk);
        while (!(in_valid && in_ready));
        sb.note_byte(b, fin);
        sent_bytes++;
    endtask

    task automatic send_file();
        int i;
        for (i = 0; i < file_bytes.size(); i++)
            send_byte(file_bytes[i], i == file_bytes.size() - 1);
    endtask

    // stop sending and let every pending result word come out
    task automatic drain();
        in_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    task automatic put_byte(input logic [7:0] b);
        file_bytes.insert(file_bytes.size(), b);
    endtask

    task automatic put_word(input logic [31:0] w);
        put_byte(w[7:0]);
        put_byte(w[15:8]);
        put_byte(w[23:16]);
        put_byte(w[31:24]);
    endtask

    task automatic patch_word(input int pos, input logic [31:0] w);
        file_bytes[pos]     = w[7:0];
        file_bytes[pos + 1] = w[15:8];
        file_bytes[pos + 2] = w[23:16];
        file_bytes[pos + 3] = w[31:24];
    endtask

    task automatic start_file(input logic [31:0] magic, input logic [31:0] version);
        file_bytes.delete();
        put_word(magic);
        put_word(version);
        put_word(32'd0);
    endtask

    task automatic put_chunk(input logic [31:0] len_field, input logic [31:0] ctype,
                             input int plen);
        put_word(len_field);
        put_word(ctype);
        repeat (plen) put_byte(8'($urandom_range(0, 255)));
    endtask

    task automatic run_directed();
        // single byte, then a header one byte short
        file_bytes.delete();
        put_byte(8'h00);
        send_file();
        start_file(glbcp_pkg::GLB_MAGIC, glbcp_pkg::GLB_VERSION);
        void'(file_bytes.pop_back());
        send_file();

        // clean file with JSON and BIN, payload bytes at both extremes
        start_file(glbcp_pkg::GLB_MAGIC, glbcp_pkg::GLB_VERSION);
        put_word(32'd4);
        put_word(glbcp_pkg::CHUNK_TYPE_JSON);
        put_word(32'hFF00_FF00);
        put_chunk(32'd2, glbcp_pkg::CHUNK_TYPE_BIN, 0);
        put_byte(8'hFF);
        put_byte(8'h00);
        patch_word(8, 32'(file_bytes.size()));
        send_file();

        // bad magic wins over bad version
        start_file(32'hFFFF_FFFF, 32'd3);
        patch_word(8, 32'd12);
        send_file();

        // bad version wins over oversized length
        start_file(glbcp_pkg::GLB_MAGIC, 32'd1);
        patch_word(8, 32'hFFFF_FFFF);
        send_file();

        // oversized length wins over chunk overrun
        start_file(glbcp_pkg::GLB_MAGIC, glbcp_pkg::GLB_VERSION);
        put_chunk(32'hFFFF_FFFF, glbcp_pkg::CHUNK_TYPE_JSON, 2);
        patch_word(8, 32'hFFFF_FFFF);
        send_file();

        // chunk overrun
        start_file(glbcp_pkg::GLB_MAGIC, glbcp_pkg::GLB_VERSION);
        put_chunk(32'hFFFF_FFFF, glbcp_pkg::CHUNK_TYPE_JSON, 2);
        patch_word(8, 32'(file_bytes.size()));
        send_file();

        // BIN only
        start_file(glbcp_pkg::GLB_MAGIC, glbcp_pkg::GLB_VERSION);
        put_chunk(32'd5, glbcp_pkg::CHUNK_TYPE_BIN, 5);
        patch_word(8, 32'(file_bytes.size()));
        send_file();

        // empty, unknown and repeated chunks, short tail, junk past the length
        start_file(glbcp_pkg::GLB_MAGIC, glbcp_pkg::GLB_VERSION);
        put_chunk(32'd0, glbcp_pkg::CHUNK_TYPE_JSON, 0);
        put_chunk(32'd0, glbcp_pkg::CHUNK_TYPE_BIN, 0);
        put_chunk(32'd3, 32'h1234_5678, 3);
        put_chunk(32'd6, glbcp_pkg::CHUNK_TYPE_JSON, 6);
        put_chunk(32'd2, glbcp_pkg::CHUNK_TYPE_JSON, 2);
        put_chunk(32'd1, glbcp_pkg::CHUNK_TYPE_BIN, 1);
        put_chunk(32'd4, glbcp_pkg::CHUNK_TYPE_BIN, 4);
        repeat (5) put_byte(8'hFF);
        patch_word(8, 32'(file_bytes.size()));
        repeat (3) put_byte(8'h00);
        send_file();

        // header only
        start_file(glbcp_pkg::GLB_MAGIC, glbcp_pkg::GLB_VERSION);
        patch_word(8, 32'd12);
        send_file();
    endtask

    task automatic make_random_file();
        file_kind_t  kind;
        int          n_chunks;
        int          i;
        int          plen;
        int          pick;
        int          pos;
        int          cut;
        logic [31:0] ctype;
        logic [31:0] decl;
        logic [31:0] old_len;
        int          hdr_pos[$];

        if ($urandom_range(0, 1) == 0)
            kind = FK_CLEAN;
        else
            kind = file_kind_t'($urandom_range(1, 7));

        if (kind == FK_NOISE)
        begin
            file_bytes.delete();
            repeat ($urandom_range(1, 24)) put_byte(8'($urandom_range(0, 255)));
            if (file_bytes.size() >= 8 && $urandom_range(0, 1) == 0)
                patch_word(0, glbcp_pkg::GLB_MAGIC);
            return;
        end

        start_file(glbcp_pkg::GLB_MAGIC, glbcp_pkg::GLB_VERSION);
        n_chunks = $urandom_range(0, 3);
        for (i = 0; i < n_chunks; i++)
        begin
            hdr_pos.insert(hdr_pos.size(), file_bytes.size());
            pick = (i == 0 && $urandom_range(0, 3) != 0) ? 0 : $urandom_range(0, 9);
            plen = $urandom_range(1, 10);
            if (pick <= 3)
                ctype = glbcp_pkg::CHUNK_TYPE_JSON;
            else if (pick <= 6)
                ctype = glbcp_pkg::CHUNK_TYPE_BIN;
            else if (pick == 7)
            begin
                ctype = $urandom;
                plen  = $urandom_range(0, 6);
            end
            else
            begin
                ctype = (pick == 8) ? glbcp_pkg::CHUNK_TYPE_JSON : glbcp_pkg::CHUNK_TYPE_BIN;
                plen  = 0;
            end
            put_chunk(32'(plen), ctype, plen);
        end
        // tail too short for a chunk header, inside the declared length
        if ($urandom_range(0, 3) == 0)
            repeat ($urandom_range(1, 7)) put_byte(8'($urandom_range(0, 255)));
        decl = 32'(file_bytes.size());
        if ($urandom_range(0, 3) == 0)
            repeat ($urandom_range(1, 6)) put_byte(8'($urandom_range(0, 255)));

        case (kind)
            FK_MAGIC:
            begin
                pos = $urandom_range(0, 3);
                file_bytes[pos] = file_bytes[pos] ^ (8'd1 << $urandom_range(0, 7));
            end
            FK_VERSION:
            begin
                pos = $urandom_range(4, 7);
                file_bytes[pos] = file_bytes[pos] ^ (8'd1 << $urandom_range(0, 7));
            end
            FK_LONG_DECL:
                decl = ($urandom_range(0, 3) == 0) ? 32'hFFFF_FFFF
                                                   : decl + $urandom_range(1, 64);
            FK_SHORT_DECL:
                decl = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 11)
                                                   : $urandom_range(12, decl);
            FK_OVERRUN:
            begin
                if (hdr_pos.size() != 0)
                begin
                    pos = hdr_pos[$urandom_range(0, hdr_pos.size() - 1)];
                    old_len = {file_bytes[pos + 3], file_bytes[pos + 2],
                               file_bytes[pos + 1], file_bytes[pos]};
                    if ($urandom_range(0, 1) == 0)
                        patch_word(pos, old_len + $urandom_range(1, 40));
                    else
                        patch_word(pos, {28'hFFF_FFFF, 4'($urandom_range(0, 15))});
                end
            end
            default:
            begin
            end
        endcase
        patch_word(8, decl);

        if (kind == FK_TRUNCATE)
        begin
            cut = $urandom_range(1, file_bytes.size() - 1);
            repeat (cut) void'(file_bytes.pop_back());
        end
    endtask

    initial
    begin
        int files_sent;
        int random_start;

        sb         = new();
        calm       = 1'b0;
        sent_bytes = 0;
        stall_left = 0;
        files_sent = 0;
        rst_n      <= 1'b0;
        in_valid   <= 1'b0;
        data_byte  <= 8'd0;
        last_byte  <= 1'b0;
        out_ready  <= 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        run_directed();
        drain();

        random_start = sent_bytes;
        while (sent_bytes - random_start < RANDOM_BYTES || files_sent < MIN_FILES)
        begin
            if (sent_bytes - random_start >= CALM_BYTES)
                calm = 1'b1;
            make_random_file();
            send_file();
            files_sent++;
            if (files_sent == 8)
                drain();
        end

        drain();
        repeat (8) @(posedge clk);
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/core/glbcp_pkg.sv
rtl/core/glbcp_in_stage.sv
rtl/core/glbcp_core.sv
rtl/core/glbcp_out_stage.sv
rtl/core/glb_container_chunk_parser.sv
test/glb_container_chunk_parser_test.sv
